[rtl/core/essr_pkg.sv]
// shared constants, field widths and control structs for the resampler
// no dependencies; imported by the controller, the datapath and the top level
package essr_pkg;

  // default configuration
  localparam int PARTICLES_DEF   = 64;
  localparam int WEIGHT_BITS_DEF = 16;

  // fixed field widths of the stream beats
  localparam int WEIGHT_IN_W = 16;
  localparam int OFFSET_W    = 10;
  localparam int IDX_W       = 6;
  localparam int CNT_W       = 7;
  localparam int IN_DATA_W   = 32;
  localparam int OUT_DATA_W  = 8;

  // controller to datapath commands
  typedef struct packed {
    logic load;        // input beat accepted
    logic clear;       // end of run, drop fill count and square sum
    logic read_first;  // fetch entry zero of the weight store
    logic walk_init;   // start the cumulative walk
    logic step;        // advance the walk by one particle
    logic emit;        // present a resampled index
    logic emit_skip;   // present the single kept-particles beat
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic keep;         // effective sample size test passed
    logic step_needed;  // current point lies beyond the cumulative weight
    logic last_slot;    // current output slot is the last one
    logic out_free;     // output register can take a beat
  } status_t;

endpackage

[rtl/core/essr_ram.sv]
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module essr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[rtl/core/essr_ctrl.sv]
// run controller: load, decision and walk sequencing
// depends on essr_pkg
module essr_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_tvalid_i,
  input  logic             s_tlast_i,
  output logic             s_tready_o,
  input  essr_pkg::status_t status_i,
  output essr_pkg::cmd_t    cmd_o
);

  import essr_pkg::*;

  localparam logic [2:0] ST_LOAD   = 3'd0;
  localparam logic [2:0] ST_FIN    = 3'd1;
  localparam logic [2:0] ST_DECIDE = 3'd2;
  localparam logic [2:0] ST_SKIP   = 3'd3;
  localparam logic [2:0] ST_PRIME  = 3'd4;
  localparam logic [2:0] ST_WALK   = 3'd5;

  logic [2:0] state_q, state_d;
  logic       accept;

  assign s_tready_o = (state_q == ST_LOAD);
  assign accept     = s_tvalid_i && s_tready_o;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_LOAD: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          if (s_tlast_i) begin
            state_d = ST_FIN;
          end
        end
      end
      // last square drains into the sum
      ST_FIN: begin
        state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (status_i.keep) begin
          state_d = ST_SKIP;
        end else begin
          cmd_o.read_first = 1'b1;
          state_d          = ST_PRIME;
        end
      end
      ST_SKIP: begin
        if (status_i.out_free) begin
          cmd_o.emit_skip = 1'b1;
          cmd_o.clear     = 1'b1;
          state_d         = ST_LOAD;
        end
      end
      ST_PRIME: begin
        cmd_o.walk_init = 1'b1;
        state_d         = ST_WALK;
      end
      ST_WALK: begin
        if (status_i.step_needed) begin
          cmd_o.step = 1'b1;
        end else if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (status_i.last_slot) begin
            cmd_o.clear = 1'b1;
            state_d     = ST_LOAD;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[rtl/core/essr_dp.sv]
// datapath: weight store, square sum, cumulative walk and output register
// depends on essr_pkg and essr_ram
module essr_dp #(
  parameter int PARTICLES   = essr_pkg::PARTICLES_DEF,
  parameter int WEIGHT_BITS = essr_pkg::WEIGHT_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  essr_pkg::cmd_t                  cmd_i,
  output essr_pkg::status_t               status_o,
  input  logic [essr_pkg::IN_DATA_W-1:0]  in_data_i,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output logic [essr_pkg::OUT_DATA_W-1:0] out_data_o,
  output logic                            out_resampled_o,
  output logic                            out_last_o
);

  import essr_pkg::*;

  localparam int WE  = (WEIGHT_BITS < WEIGHT_IN_W) ? WEIGHT_BITS : WEIGHT_IN_W;
  localparam int AW  = $clog2(PARTICLES);
  localparam int SW  = 2 * WE + CNT_W - 1;
  localparam int CW  = WE + CNT_W - 1;
  localparam int UW  = ((WEIGHT_BITS > OFFSET_W) ? WEIGHT_BITS : OFFSET_W) + 1;
  localparam int MW  = (UW > CW) ? UW : CW;
  localparam int FW  = AW + 1;
  localparam logic [63:0] STEP_Q = (64'd1 << WEIGHT_BITS) / PARTICLES;
  localparam logic [63:0] STEP_R = (64'd1 << WEIGHT_BITS) % PARTICLES;
  // n * sum_sq <= 2^(2*wb+1)  <=>  sum_sq <= floor(2^(2*wb+1) / n)
  localparam logic [63:0] KEEP_LIMIT = (2 * WEIGHT_BITS + 1 >= 63) ? {64{1'b1}} :
                                       (64'd1 << (2 * WEIGHT_BITS + 1)) / PARTICLES;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PARTICLES - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(PARTICLES);

  logic [WE-1:0]       weight;
  logic                store_we;
  logic [CNT_W-1:0]    cnt_q;
  logic [SW-1:0]       sum_q;
  logic [2*WE-1:0]     prod_q;
  logic                prod_vld_q;
  logic [OFFSET_W-1:0] r_q;
  logic [WE-1:0]       rdata;
  logic [WE-1:0]       rd_weight;
  logic                rd_vld_q;
  logic                rd_ok;
  logic [AW-1:0]       raddr;
  logic [IDX_W-1:0]    idx_q, idx_d;
  logic [CNT_W-1:0]    idx_nxt;
  logic [CW-1:0]       cum_q;
  logic [IDX_W-1:0]    m_q;
  logic [WEIGHT_BITS-1:0] base_q;
  logic [FW-1:0]       frac_q;
  logic [FW-1:0]       frac_sum;
  logic                frac_carry;
  logic [UW-1:0]       point;
  logic                out_valid_q;
  logic [IDX_W-1:0]    out_idx_q;
  logic                out_res_q;
  logic                out_last_q;

  assign weight   = in_data_i[WE-1:0];
  assign store_we = cmd_i.load && (cnt_q < FULL_CNT);

  // weight store
  essr_ram #(
    .WIDTH (WE),
    .DEPTH (1 << AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i (weight),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // fill count and square accumulation
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      sum_q      <= '0;
      prod_vld_q <= 1'b0;
    end else begin
      prod_vld_q <= store_we;
      if (cmd_i.clear) begin
        cnt_q <= '0;
        sum_q <= '0;
      end else begin
        if (store_we) begin
          cnt_q <= cnt_q + 1'b1;
        end
        if (prod_vld_q) begin
          sum_q <= sum_q + SW'(prod_q);
        end
      end
    end
  end

  // square and offset capture, the final beat's offset is the one kept
  always_ff @(posedge clk_i) begin
    prod_q <= weight * weight;
    if (cmd_i.load) begin
      r_q <= in_data_i[WEIGHT_IN_W +: OFFSET_W];
    end
  end

  // next walk index and prefetch of the entry after it
  always_comb begin
    idx_d = idx_q;
    if (cmd_i.walk_init) begin
      idx_d = '0;
    end else if (cmd_i.step) begin
      idx_d = idx_q + 1'b1;
    end
  end

  assign idx_nxt = {1'b0, idx_d} + 1'b1;
  assign raddr   = cmd_i.read_first ? '0 : idx_nxt[AW-1:0];
  // entries past the fill count read as zero weight
  assign rd_ok   = cmd_i.read_first ? (cnt_q != '0) : (idx_nxt < cnt_q);
  assign rd_weight = rd_vld_q ? rdata : '0;

  // systematic points: base = floor(m * 2^wb / n) built incrementally
  assign frac_sum   = frac_q + FW'(STEP_R);
  assign frac_carry = (frac_sum >= FW'(PARTICLES));
  assign point      = UW'(r_q) + UW'(base_q);

  // walk registers
  always_ff @(posedge clk_i) begin
    rd_vld_q <= rd_ok;
    idx_q    <= idx_d;
    if (cmd_i.walk_init) begin
      cum_q  <= CW'(rd_weight);
      m_q    <= '0;
      base_q <= '0;
      frac_q <= '0;
    end else begin
      if (cmd_i.step) begin
        cum_q <= cum_q + CW'(rd_weight);
      end
      if (cmd_i.emit) begin
        m_q    <= m_q + 1'b1;
        base_q <= base_q + WEIGHT_BITS'(STEP_Q) + WEIGHT_BITS'(frac_carry);
        frac_q <= frac_carry ? (frac_sum - FW'(PARTICLES)) : frac_sum;
      end
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit || cmd_i.emit_skip) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_idx_q  <= idx_q;
      out_res_q  <= 1'b1;
      out_last_q <= (m_q == LAST_IDX);
    end else if (cmd_i.emit_skip) begin
      out_idx_q  <= '0;
      out_res_q  <= 1'b0;
      out_last_q <= 1'b1;
    end
  end

  // status back to the controller
  assign status_o.keep        = (64'(sum_q) <= KEEP_LIMIT);
  assign status_o.step_needed = (MW'(point) > MW'(cum_q)) && (idx_q != LAST_IDX);
  assign status_o.last_slot   = (m_q == LAST_IDX);
  assign status_o.out_free    = !out_valid_q || out_ready_i;

  assign out_valid_o     = out_valid_q;
  assign out_data_o      = OUT_DATA_W'(out_idx_q);
  assign out_resampled_o = out_res_q;
  assign out_last_o      = out_last_q;

endmodule

[rtl/core/ess_gated_systematic_resampler.sv]
// top level of the effective-sample-size gated systematic resampler
// depends on essr_pkg, essr_ctrl, essr_dp and essr_ram
//
// Usage: the slave stream takes one particle weight per beat, tdata holding
// weight (bits 15:0, Q0.16) and offset (bits 25:16); tlast marks the Nth
// weight and starts the run, and its offset is the random start point.
// Weights load at one beat per cycle into a 64-entry store while their
// squares are summed. The final square drains into the sum in ST_FIN and
// ST_DECIDE tests it. If N * sum_sq <= 2 the particles are kept and one beat
// with tuser = 0 and tlast = 1 goes out. Otherwise N beats carry source
// indices with tuser = 1, tlast on the last. The walk emits an index or
// advances the cumulative sum by one particle, at most N - 1 advances, the
// single store read port feeding the running sum. The slave side is not
// ready from the last beat until the run's final beat is registered. A
// stalled master side holds the output register and the next emit but not
// the sum advances. Reset empties the store fill count and the square sum;
// no clearing pass is needed since entries past the fill count read as zero.
module ess_gated_systematic_resampler #(
  parameter int PARTICLES   = essr_pkg::PARTICLES_DEF,
  parameter int WEIGHT_BITS = essr_pkg::WEIGHT_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [essr_pkg::IN_DATA_W-1:0]  s_axis_tdata,   // weight, offset
  input  logic                            s_axis_tlast,   // final_weight
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [essr_pkg::OUT_DATA_W-1:0] m_axis_tdata,   // source_index
  output logic                            m_axis_tuser,   // resampled
  output logic                            m_axis_tlast    // run_end
);

  import essr_pkg::*;

  cmd_t    cmd;
  status_t status;

  // run sequencing
  essr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tlast_i  (s_axis_tlast),
    .s_tready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // store, sums and walk
  essr_dp #(
    .PARTICLES   (PARTICLES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .in_data_i       (s_axis_tdata),
    .out_ready_i     (m_axis_tready),
    .out_valid_o     (m_axis_tvalid),
    .out_data_o      (m_axis_tdata),
    .out_resampled_o (m_axis_tuser),
    .out_last_o      (m_axis_tlast)
  );

endmodule
